>>> rtl/exhaustive_group_partition_search_assert.svh
// Assertion macros for the group partition search checker.
// Expects clk and arst_n in the scope of use.
`ifndef EXHAUSTIVE_GROUP_PARTITION_SEARCH_ASSERT_SVH
`define EXHAUSTIVE_GROUP_PARTITION_SEARCH_ASSERT_SVH

// same-cycle implication
`define EGPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define EGPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/egps_pkg.sv
// Shared constants and codes for the group partition search.
// No dependencies.
`default_nettype none
package egps_pkg;
	localparam int PEOPLE_MAX_DEF  = 12;
	localparam int RATING_BITS_DEF = 8;
	localparam int ROW_TOTAL_W     = 12;
	localparam logic [ROW_TOTAL_W-1:0] ROW_TOTAL_MAX = 12'hFFF;
	localparam int SCORE_W         = 20;
	localparam logic [SCORE_W-1:0] SCORE_MAX = 20'hFFFFF;
	localparam int WEIGHT_W        = 17;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
	localparam int PAIR_W          = WEIGHT_W + 1;
	localparam int COUNT_W         = 32;
	localparam int FIELD_W         = 4;
	localparam int FRAC_BITS       = 16;

	localparam logic REG_PEOPLE = 1'b0;
	localparam logic REG_GROUP  = 1'b1;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} egps_div_stat_t;
endpackage
`default_nettype wire

>>> rtl/egps_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module egps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/egps_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on egps_pkg for the status struct.
`default_nettype none
module egps_div import egps_pkg::*; #(
	parameter int DW = 24,
	parameter int VW = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output egps_div_stat_t     stat,
	output logic      [DW-1:0] quotient
);
	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [VW-1:0] dsr_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          take;

	assign trial = {rem_q, quo_q[DW-1]};
	assign take  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? VW'(trial - {1'b0, dsr_q}) : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], take};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
endmodule
`default_nettype wire

>>> rtl/exhaustive_group_partition_search.sv
// Load: items are taken back to back while idle. Search: the divider weighs each
// person pair both ways (one quotient bit per cycle), people are labelled, then per
// arrangement each pair and row is rescored, matching-label pairs add their weight and
// the permutation is scanned; results then leave one per cycle as the sink allows.
// Reset clears rating valid bits and row totals, sets config to its defaults and resets control at once.
`default_nettype none
module exhaustive_group_partition_search import egps_pkg::*; #(
	parameter int PEOPLE_MAX  = PEOPLE_MAX_DEF,
	parameter int RATING_BITS = RATING_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic         action,
	input  wire logic [3:0]   person,
	input  wire logic [3:0]   friend_index,
	input  wire logic [7:0]   rating_value,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic      [3:0]   person_out,
	output logic      [3:0]   group_label,
	output logic      [19:0]  best_score,
	output logic      [31:0]  arrangement_count,
	output logic              last,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready
);
	localparam int IW  = $clog2(PEOPLE_MAX);
	localparam int NW  = $clog2(PEOPLE_MAX + 1);
	localparam int AW  = 2 * IW;
	localparam int RD  = 2 ** AW;
	localparam int DW  = RATING_BITS + FRAC_BITS;
	localparam int ACW = $clog2(PEOPLE_MAX * (PEOPLE_MAX - 1) * 65536 + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_WRD  = 4'd1;
	localparam logic [3:0] S_WDIV = 4'd2;
	localparam logic [3:0] S_WWT  = 4'd3;
	localparam logic [3:0] S_INIT = 4'd4;
	localparam logic [3:0] S_RS   = 4'd5;
	localparam logic [3:0] S_RSW  = 4'd6;
	localparam logic [3:0] S_EVAL = 4'd7;
	localparam logic [3:0] S_ADVK = 4'd8;
	localparam logic [3:0] S_ADVL = 4'd9;
	localparam logic [3:0] S_SWAP = 4'd10;
	localparam logic [3:0] S_REV  = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	logic [3:0]             state_q;
	logic [3:0]             pc_q;
	logic [3:0]             gs_q;
	logic [NW-1:0]          n_q;
	logic [ROW_TOTAL_W-1:0] row_total_q [PEOPLE_MAX];
	logic [RD-1:0]          rvalid_q;
	logic                   rv_q;
	logic                   half_q;
	logic                   tz_q;
	logic [IW-1:0]          wi_q;
	logic [IW-1:0]          wj_q;
	logic [WEIGHT_W-1:0]    w1_q;
	logic [IW-1:0]          ii_q;
	logic [NW-1:0]          lab_q;
	logic [3:0]             cnt_q;
	logic [IW-1:0]          ri_q;
	logic [NW-1:0]          rj_q;
	logic [ACW-1:0]         acc_q;
	logic [IW-1:0]          kk_q;
	logic [IW-1:0]          k_q;
	logic [IW-1:0]          l_q;
	logic [IW-1:0]          a_q;
	logic [IW-1:0]          b_q;
	logic [SCORE_W-1:0]     best_val_q;
	logic [COUNT_W-1:0]     count_q;
	logic [IW-1:0]          oi_q;
	logic [NW-1:0]          cur_q      [PEOPLE_MAX];
	logic [NW-1:0]          best_lab_q [PEOPLE_MAX];
	logic [ACW-1:0]         prefix_q   [PEOPLE_MAX + 1];
	logic                   out_valid_q;

	logic                   in_acc;
	logic                   load_ok;
	logic [RATING_BITS-1:0] r_in;
	logic [ROW_TOTAL_W:0]   rt_sum;
	logic                   cfg_wr;
	logic [3:0]             n_eff;
	logic [3:0]             g_eff;
	logic                   out_free;
	logic [AW-1:0]          rat_raddr;
	logic [RATING_BITS-1:0] rat_rdata;
	logic                   pair_we;
	logic [PAIR_W-1:0]      pair_rdata;
	logic [ROW_TOTAL_W-1:0] div_dsr;
	logic [DW-1:0]          div_q;
	egps_div_stat_t         div_stat;
	logic                   div_start;
	logic [WEIGHT_W-1:0]    w_now;
	logic [SCORE_W-1:0]     score;
	logic [IW-1:0]          n_last;
	logic                   rs_match;
	logic                   rs_adv;
	logic                   cur_wr;
	logic [IW-1:0]          swp_x;
	logic [IW-1:0]          swp_y;
	logic                   new_best;

	assign in_stall  = state_q != S_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign r_in      = RATING_BITS'(rating_value);
	assign load_ok   = (32'(person) < PEOPLE_MAX) && (32'(friend_index) < PEOPLE_MAX);
	assign rt_sum    = {1'b0, row_total_q[person[IW-1:0]]} + (ROW_TOTAL_W + 1)'(r_in);
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_GROUP) ? 32'(gs_q) : 32'(pc_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign n_last    = IW'(n_q - 1'b1);
	assign g_eff     = (gs_q == 4'd0) ? 4'd1 : gs_q;

	always_comb begin
		if (pc_q < 4'd2) begin
			n_eff = 4'd2;
		end else if (32'(pc_q) > PEOPLE_MAX) begin
			n_eff = 4'(PEOPLE_MAX);
		end else begin
			n_eff = pc_q;
		end
	end

	assign rat_raddr = half_q ? {wj_q, wi_q} : {wi_q, wj_q};
	assign div_dsr   = row_total_q[half_q ? wj_q : wi_q];
	assign div_start = state_q == S_WDIV;
	assign w_now     = tz_q ? '0 : ((div_q > DW'(WEIGHT_ONE)) ? WEIGHT_ONE : div_q[WEIGHT_W-1:0]);
	assign pair_we   = (state_q == S_WWT) && div_stat.done && half_q;
	assign score     = (acc_q > ACW'(SCORE_MAX)) ? SCORE_MAX : acc_q[SCORE_W-1:0];
	assign new_best  = score > best_val_q;
	assign rs_match  = cur_q[ri_q] == cur_q[rj_q[IW-1:0]];
	assign rs_adv    = (state_q == S_RS) && (rj_q != n_q) && (NW'(ri_q) != rj_q);

	egps_ram #(.WIDTH(RATING_BITS), .DEPTH(RD)) u_rating (
		.clk   (clk),
		.we    (in_acc && action == ACT_LOAD && load_ok),
		.waddr ({person[IW-1:0], friend_index[IW-1:0]}),
		.wdata (r_in),
		.raddr (rat_raddr),
		.rdata (rat_rdata)
	);

	egps_ram #(.WIDTH(PAIR_W), .DEPTH(RD)) u_pair (
		.clk   (clk),
		.we    (pair_we),
		.waddr ({wi_q, wj_q}),
		.wdata (PAIR_W'(w1_q) + PAIR_W'(w_now)),
		.raddr ({ri_q, rj_q[IW-1:0]}),
		.rdata (pair_rdata)
	);

	egps_div #(.DW(DW), .VW(ROW_TOTAL_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({(rv_q ? rat_rdata : RATING_BITS'(0)), FRAC_BITS'(0)}),
		.divisor  (div_dsr),
		.stat     (div_stat),
		.quotient (div_q)
	);

	always_comb begin
		cur_wr = 1'b0;
		swp_x  = k_q;
		swp_y  = l_q;
		if (state_q == S_SWAP) begin
			cur_wr = 1'b1;
		end else if (state_q == S_REV && a_q < b_q) begin
			cur_wr = 1'b1;
			swp_x  = a_q;
			swp_y  = b_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= 4'(PEOPLE_MAX_DEF);
			gs_q        <= 4'd2;
			rvalid_q    <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < PEOPLE_MAX; i++) begin
				row_total_q[i] <= '0;
			end
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_GROUP) begin
					gs_q <= pwdata[3:0];
				end else begin
					pc_q <= pwdata[3:0];
				end
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (action == ACT_SEARCH) begin
							state_q <= S_WRD;
						end else if (load_ok) begin
							rvalid_q[{person[IW-1:0], friend_index[IW-1:0]}] <= 1'b1;
							row_total_q[person[IW-1:0]] <= rt_sum[ROW_TOTAL_W] ?
								ROW_TOTAL_MAX : rt_sum[ROW_TOTAL_W-1:0];
						end
					end
				end
				S_WRD:  state_q <= S_WDIV;
				S_WDIV: state_q <= S_WWT;
				S_WWT: begin
					if (div_stat.done) begin
						if (half_q && wj_q == n_last && wi_q == IW'(n_q - 2'd2)) begin
							state_q <= S_INIT;
						end else begin
							state_q <= S_WRD;
						end
					end
				end
				S_INIT: begin
					if (ii_q == n_last) begin
						state_q <= S_RS;
					end
				end
				S_RS: begin
					if (rj_q == n_q) begin
						state_q <= S_EVAL;
					end else if (rs_adv && rs_match) begin
						state_q <= S_RSW;
					end
				end
				S_RSW:  state_q <= S_RS;
				S_EVAL: state_q <= S_ADVK;
				S_ADVK: begin
					if (kk_q == '0) begin
						state_q <= S_OUT;
					end else if (cur_q[kk_q - 1'b1] < cur_q[kk_q]) begin
						state_q <= S_ADVL;
					end
				end
				S_ADVL: begin
					if (cur_q[l_q] > cur_q[k_q]) begin
						state_q <= S_SWAP;
					end
				end
				S_SWAP: state_q <= S_REV;
				S_REV: begin
					if (!(a_q < b_q)) begin
						state_q <= S_RS;
					end
				end
				S_OUT: begin
					if (out_free && oi_q == n_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cur_wr) begin
			cur_q[swp_x] <= cur_q[swp_y];
			cur_q[swp_y] <= cur_q[swp_x];
		end
		unique case (state_q)
			S_IDLE: begin
				n_q    <= NW'(n_eff);
				wi_q   <= '0;
				wj_q   <= IW'(1);
				half_q <= 1'b0;
			end
			S_WRD: begin
				rv_q <= rvalid_q[rat_raddr];
			end
			S_WDIV: begin
				tz_q <= div_dsr == '0;
			end
			S_WWT: begin
				if (div_stat.done) begin
					half_q <= !half_q;
					if (!half_q) begin
						w1_q <= w_now;
					end else if (wj_q == n_last) begin
						wi_q <= wi_q + 1'b1;
						wj_q <= wi_q + IW'(2);
					end else begin
						wj_q <= wj_q + 1'b1;
					end
				end
				ii_q  <= '0;
				lab_q <= NW'(1);
				cnt_q <= '0;
			end
			S_INIT: begin
				cur_q[ii_q]      <= lab_q;
				best_lab_q[ii_q] <= lab_q;
				ii_q             <= ii_q + 1'b1;
				if (cnt_q + 1'b1 == g_eff) begin
					lab_q <= lab_q + 1'b1;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
				best_val_q <= '0;
				count_q    <= '0;
				acc_q      <= '0;
				ri_q       <= '0;
				rj_q       <= '0;
			end
			S_RS: begin
				if (rj_q != n_q) begin
					if (NW'(ri_q) == rj_q) begin
						prefix_q[rj_q + 1'b1] <= acc_q;
						rj_q <= rj_q + 1'b1;
						ri_q <= '0;
					end else begin
						ri_q <= ri_q + 1'b1;
					end
				end
			end
			S_RSW: begin
				acc_q <= acc_q + ACW'(pair_rdata);
			end
			S_EVAL: begin
				if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
				if (new_best) begin
					best_val_q <= score;
					best_lab_q <= cur_q;
				end
				kk_q <= n_last;
			end
			S_ADVK: begin
				if (kk_q != '0) begin
					if (cur_q[kk_q - 1'b1] >= cur_q[kk_q]) begin
						kk_q <= kk_q - 1'b1;
					end else begin
						k_q <= kk_q - 1'b1;
						l_q <= n_last;
					end
				end
				oi_q <= '0;
			end
			S_ADVL: begin
				if (cur_q[l_q] <= cur_q[k_q]) begin
					l_q <= l_q - 1'b1;
				end
			end
			S_SWAP: begin
				a_q <= k_q + 1'b1;
				b_q <= n_last;
			end
			S_REV: begin
				if (a_q < b_q) begin
					a_q <= a_q + 1'b1;
					b_q <= b_q - 1'b1;
				end else begin
					acc_q <= (k_q == '0) ? '0 : prefix_q[NW'(k_q)];
					rj_q  <= NW'(k_q);
					ri_q  <= '0;
				end
			end
			S_OUT: begin
				if (out_free) begin
					person_out        <= FIELD_W'(oi_q);
					group_label       <= FIELD_W'(best_lab_q[oi_q]);
					best_score        <= best_val_q;
					arrangement_count <= count_q;
					last              <= oi_q == n_last;
					oi_q              <= oi_q + 1'b1;
				end
			end
			default: begin
				rv_q <= 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

>>> rtl/egps_checker.sv
// Port-level checks for the group partition search, bound to the top level.
// Depends on exhaustive_group_partition_search_assert.svh.
`default_nettype none
`include "exhaustive_group_partition_search_assert.svh"
module egps_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        action,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [3:0]  group_label,
	input wire logic [31:0] arrangement_count,
	input wire logic        last
);
	`EGPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(group_label))
	`EGPS_ASSERT_NOW(a_busy_rows, out_valid && !last, in_stall)
	`EGPS_ASSERT_NOW(a_row_sane, out_valid, group_label != 4'd0 && arrangement_count != 32'd0)
	`EGPS_ASSERT_NEXT(a_search_busy, in_valid && !in_stall && action, in_stall)
endmodule

bind exhaustive_group_partition_search egps_checker u_egps_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_stall          (in_stall),
	.action            (action),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.group_label       (group_label),
	.arrangement_count (arrangement_count),
	.last              (last)
);
`default_nettype wire
